/* rtl/sncs_pkg.sv */
// ----------------------------------------------------------------------------
// sncs_pkg
// shared types, opcodes and sizing for the serial nor flash command sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package sncs_pkg;

    // geometry of the attached flash
    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int ADDR_BITS    = 24;

    // derived sizes
    localparam int ADDR_BYTES  = (ADDR_BITS + 7) / 8;
    localparam int OFF_W       = $clog2(PAGE_BYTES);
    localparam int SECT_SHIFT  = $clog2(SECTOR_BYTES);
    localparam int MAX_BEATS   = (2 + ADDR_BYTES > 6) ? (2 + ADDR_BYTES) : 6;
    localparam int CNT_W       = $clog2(MAX_BEATS + 1);

    // request codes
    typedef enum logic [3:0] {
        FN_RDSR      = 4'd0,
        FN_WRSR      = 4'd1,
        FN_WREN      = 4'd2,
        FN_WRDIS     = 4'd3,
        FN_ID        = 4'd4,
        FN_CHIPERASE = 4'd5,
        FN_SECTERASE = 4'd6,
        FN_PDOWN     = 4'd7,
        FN_WAKE      = 4'd8,
        FN_RDBEGIN   = 4'd9,
        FN_RDNEXT    = 4'd10,
        FN_PROGBEGIN = 4'd11,
        FN_PROGBYTE  = 4'd12
    } func_t;

    // flash opcodes
    localparam logic [7:0] OP_RDSR    = 8'h05;
    localparam logic [7:0] OP_WRSR    = 8'h01;
    localparam logic [7:0] OP_WREN    = 8'h06;
    localparam logic [7:0] OP_WRDIS   = 8'h04;
    localparam logic [7:0] OP_ID      = 8'h90;
    localparam logic [7:0] OP_CHIPER  = 8'hC7;
    localparam logic [7:0] OP_SECTER  = 8'h20;
    localparam logic [7:0] OP_PDOWN   = 8'hB9;
    localparam logic [7:0] OP_WAKE    = 8'hAB;
    localparam logic [7:0] OP_READ    = 8'h03;
    localparam logic [7:0] OP_PROG    = 8'h02;
    localparam logic [7:0] DUMMY_BYTE = 8'hFF;

    // open transaction kind
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_READ = 2'd1,
        KIND_PROG = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [OFF_W-1:0] offset;
    } seq_state_t;

    // one bus byte with its marks
    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       capture_miso;
        logic       release_select;
        logic       last_of_run;
        logic       page_full;
        logic       sequence_error;
    } beat_t;

    typedef beat_t [MAX_BEATS-1:0] beat_vec_t;

    function automatic beat_t mk_beat(input logic [7:0] b, input logic cap,
                                      input logic rel);
        beat_t r;
        r                = '0;
        r.mosi_byte      = b;
        r.capture_miso   = cap;
        r.release_select = rel;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/spi_nor_flash_command_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_unit
// host-side serial nor flash command sequencer: one request in, the bus bytes
// to shift out, each with chip select release and miso capture marks
// ----------------------------------------------------------------------------
//
//  channel   prefix  direction  one beat carries
//  -------   ------  ---------  ---------------------------------------------
//  request   s_      in         func, address, data_byte, data_last
//  bus byte  m_      out        mosi_byte, capture_miso, release_select,
//                               last_of_run, page_full, sequence_error
//
//  a request is decoded in the cycle it is accepted and lands as 1 to 6 beats
//  in the beat buffer; the first beat is valid on the next cycle
//  the buffer drains one beat per cycle while m_ready is high; the next request
//  is taken in the cycle the last beat leaves
//  output stall holds the buffer and blocks new requests until its last beat
//  aresetn (synchronous, low) empties the buffer and closes any transaction
// ----------------------------------------------------------------------------
`default_nettype none

module spi_nor_flash_command_sequencer_unit import sncs_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [3:0]  s_func,
    input  wire logic [23:0] s_address,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_data_last,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_mosi_byte,
    output logic             m_capture_miso,
    output logic             m_release_select,
    output logic             m_last_of_run,
    output logic             m_page_full,
    output logic             m_sequence_error
);

    // transaction state: open kind and byte position in the program page
    seq_state_t        state_reg;
    seq_state_t        state_next;

    // beat buffer: entry 0 is the beat on the output
    beat_vec_t         beats_reg;
    beat_vec_t         beats_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    // decoder results for the request on the input
    beat_vec_t         dec_beats;
    logic [CNT_W-1:0]  dec_count;
    seq_state_t        dec_state;

    logic              s_fire;
    logic              m_fire;

    sncs_decode u_decode (
        .func      (s_func),
        .address   (s_address),
        .data_byte (s_data_byte),
        .data_last (s_data_last),
        .cur       (state_reg),
        .beats     (dec_beats),
        .count     (dec_count),
        .nxt       (dec_state)
    );

    // take a request when the buffer is empty or its last beat leaves now
    assign s_ready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && m_ready);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (cnt_reg != '0);
    assign m_fire  = m_valid && m_ready;

    assign m_mosi_byte      = beats_reg[0].mosi_byte;
    assign m_capture_miso   = beats_reg[0].capture_miso;
    assign m_release_select = beats_reg[0].release_select;
    assign m_last_of_run    = beats_reg[0].last_of_run;
    assign m_page_full      = beats_reg[0].page_full;
    assign m_sequence_error = beats_reg[0].sequence_error;

    always_comb begin
        beats_next = beats_reg;
        cnt_next   = cnt_reg;
        state_next = state_reg;
        if (s_fire) begin
            // state moves at accept time, the beats follow from the buffer
            beats_next = dec_beats;
            cnt_next   = dec_count;
            state_next = dec_state;
        end else if (m_fire) begin
            for (int i = 0; i < MAX_BEATS - 1; i++) begin
                beats_next[i] = beats_reg[i+1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        beats_reg <= beats_next;
        if (!aresetn) begin
            cnt_reg          <= '0;
            state_reg.kind   <= KIND_NONE;
            state_reg.offset <= '0;
        end else begin
            cnt_reg   <= cnt_next;
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    // buffer never holds more beats than the longest request
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_BEATS))
        else $error("beat count out of range");

    // an accepted request always shows a beat on the next cycle
    a_accept_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid)
        else $error("request accepted without a beat");

    // the run marker sits on the final buffered beat only
    a_last_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_of_run == (cnt_reg == CNT_W'(1))))
        else $error("run marker misplaced");

    // page offset only moves inside an open program transaction
    a_offset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.kind != KIND_PROG) |-> (state_reg.offset == '0))
        else $error("page offset left over outside program");

    // a page-full beat always releases select
    a_full_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_page_full) |-> m_release_select)
        else $error("page full without select release");
`endif

endmodule

`default_nettype wire

/* rtl/sncs_decode.sv */
// ----------------------------------------------------------------------------
// sncs_decode
// turns one request and the transaction state into its bus beats
// ----------------------------------------------------------------------------
`default_nettype none

module sncs_decode import sncs_pkg::*; (
    input  wire logic [3:0]       func,
    input  wire logic [23:0]      address,
    input  wire logic [7:0]       data_byte,
    input  wire logic             data_last,
    input  wire seq_state_t       cur,
    output beat_vec_t             beats,
    output logic [CNT_W-1:0]      count,
    output seq_state_t            nxt
);

    logic                      ok;
    logic                      full;
    logic [ADDR_BITS-1:0]      byte_addr;
    logic [ADDR_BITS-1:0]      sect_addr;
    logic [ADDR_BYTES*8-1:0]   byte_pad;
    logic [ADDR_BYTES*8-1:0]   sect_pad;

    assign byte_addr = ADDR_BITS'(address);
    assign sect_addr = ADDR_BITS'({address, {SECT_SHIFT{1'b0}}});
    assign byte_pad  = (ADDR_BYTES*8)'(byte_addr);
    assign sect_pad  = (ADDR_BYTES*8)'(sect_addr);
    assign full      = (cur.offset == OFF_W'(PAGE_BYTES - 1));

    always_comb begin
        unique case (cur.kind)
            KIND_READ: ok = (func == FN_RDNEXT);
            KIND_PROG: ok = (func == FN_PROGBYTE);
            default:   ok = (func <= FN_RDBEGIN) || (func == FN_PROGBEGIN);
        endcase
    end

    always_comb begin
        beats = '0;
        count = '0;
        nxt   = cur;
        if (!ok) begin
            beats[0].sequence_error = 1'b1;
            count = CNT_W'(1);
        end else begin
            unique case (func)
                FN_RDSR: begin
                    beats[0] = mk_beat(OP_RDSR, 1'b0, 1'b0);
                    beats[1] = mk_beat(DUMMY_BYTE, 1'b1, 1'b1);
                    count    = CNT_W'(2);
                end
                FN_WRSR: begin
                    beats[0] = mk_beat(OP_WRSR, 1'b0, 1'b0);
                    beats[1] = mk_beat(data_byte, 1'b0, 1'b1);
                    count    = CNT_W'(2);
                end
                FN_WREN: begin
                    beats[0] = mk_beat(OP_WREN, 1'b0, 1'b1);
                    count    = CNT_W'(1);
                end
                FN_WRDIS: begin
                    beats[0] = mk_beat(OP_WRDIS, 1'b0, 1'b1);
                    count    = CNT_W'(1);
                end
                FN_ID: begin
                    beats[0] = mk_beat(OP_ID, 1'b0, 1'b0);
                    beats[1] = mk_beat(8'h00, 1'b0, 1'b0);
                    beats[2] = mk_beat(8'h00, 1'b0, 1'b0);
                    beats[3] = mk_beat(8'h00, 1'b0, 1'b0);
                    beats[4] = mk_beat(DUMMY_BYTE, 1'b1, 1'b0);
                    beats[5] = mk_beat(DUMMY_BYTE, 1'b1, 1'b1);
                    count    = CNT_W'(6);
                end
                FN_CHIPERASE: begin
                    beats[0] = mk_beat(OP_WREN, 1'b0, 1'b1);
                    beats[1] = mk_beat(OP_CHIPER, 1'b0, 1'b1);
                    count    = CNT_W'(2);
                end
                FN_SECTERASE: begin
                    beats[0] = mk_beat(OP_WREN, 1'b0, 1'b1);
                    beats[1] = mk_beat(OP_SECTER, 1'b0, 1'b0);
                    for (int i = 0; i < ADDR_BYTES; i++) begin
                        beats[2+i] = mk_beat(sect_pad[8*(ADDR_BYTES-1-i) +: 8], 1'b0,
                                             (i == ADDR_BYTES - 1));
                    end
                    count = CNT_W'(2 + ADDR_BYTES);
                end
                FN_PDOWN: begin
                    beats[0] = mk_beat(OP_PDOWN, 1'b0, 1'b1);
                    count    = CNT_W'(1);
                end
                FN_WAKE: begin
                    beats[0] = mk_beat(OP_WAKE, 1'b0, 1'b1);
                    count    = CNT_W'(1);
                end
                FN_RDBEGIN: begin
                    beats[0] = mk_beat(OP_READ, 1'b0, 1'b0);
                    for (int i = 0; i < ADDR_BYTES; i++) begin
                        beats[1+i] = mk_beat(byte_pad[8*(ADDR_BYTES-1-i) +: 8], 1'b0, 1'b0);
                    end
                    count    = CNT_W'(1 + ADDR_BYTES);
                    nxt.kind = KIND_READ;
                end
                FN_RDNEXT: begin
                    beats[0] = mk_beat(DUMMY_BYTE, 1'b1, data_last);
                    count    = CNT_W'(1);
                    if (data_last) begin
                        nxt.kind = KIND_NONE;
                    end
                end
                FN_PROGBEGIN: begin
                    beats[0] = mk_beat(OP_WREN, 1'b0, 1'b1);
                    beats[1] = mk_beat(OP_PROG, 1'b0, 1'b0);
                    for (int i = 0; i < ADDR_BYTES; i++) begin
                        beats[2+i] = mk_beat(byte_pad[8*(ADDR_BYTES-1-i) +: 8], 1'b0, 1'b0);
                    end
                    count      = CNT_W'(2 + ADDR_BYTES);
                    nxt.kind   = KIND_PROG;
                    nxt.offset = byte_addr[OFF_W-1:0];
                end
                FN_PROGBYTE: begin
                    beats[0]           = mk_beat(data_byte, 1'b0, data_last | full);
                    beats[0].page_full = full;
                    count              = CNT_W'(1);
                    if (data_last || full) begin
                        nxt.kind   = KIND_NONE;
                        nxt.offset = '0;
                    end else begin
                        nxt.offset = cur.offset + OFF_W'(1);
                    end
                end
                default: begin
                    // unknown codes never pass the legality check
                    count = CNT_W'(1);
                    beats[0].sequence_error = 1'b1;
                end
            endcase
        end
        // mark the final beat of this request
        for (int i = 0; i < MAX_BEATS; i++) begin
            beats[i].last_of_run = (CNT_W'(i + 1) == count);
        end
    end

endmodule

`default_nettype wire

/* sim/sncs_bus_byte_checker.sv */
// ----------------------------------------------------------------------------
// sncs_bus_byte_checker
// watches the request and bus byte channels of the flash command sequencer,
// predicts the bus bytes of every accepted request and compares them in order
// ----------------------------------------------------------------------------
module sncs_bus_byte_checker import sncs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [3:0]  s_func,
    input  logic [23:0] s_address,
    input  logic [7:0]  s_data_byte,
    input  logic        s_data_last,

    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_mosi_byte,
    input  logic        m_capture_miso,
    input  logic        m_release_select,
    input  logic        m_last_of_run,
    input  logic        m_page_full,
    input  logic        m_sequence_error,

    output int          mismatches,
    output int          outstanding
);

    // predicted transaction state
    kind_t txn_kind;
    int    page_pos;

    // bus bytes of the request being predicted, then the ones still owed
    beat_t plan [MAX_BEATS];
    int    plan_n;
    beat_t expected_bytes [$];

    task automatic add_byte(input logic [7:0] b, input logic cap, input logic rel);
        plan[plan_n]                = '0;
        plan[plan_n].mosi_byte      = b;
        plan[plan_n].capture_miso   = cap;
        plan[plan_n].release_select = rel;
        plan_n++;
    endtask

    // address bytes, most significant first
    task automatic add_addr(input logic [ADDR_BITS-1:0] a);
        for (int i = ADDR_BYTES - 1; i >= 0; i--) begin
            add_byte(8'(a >> (8 * i)), 1'b0, 1'b0);
        end
    endtask

    task automatic plan_bus_bytes(input logic [3:0] func,
                                  input logic [ADDR_BITS-1:0] addr,
                                  input logic [7:0] data, input logic last);
        logic                 legal;
        logic                 full;
        logic [ADDR_BITS-1:0] sect_addr;
        plan_n = 0;
        case (txn_kind)
            KIND_READ: legal = (func == FN_RDNEXT);
            KIND_PROG: legal = (func == FN_PROGBYTE);
            default:   legal = (func <= FN_RDBEGIN) || (func == FN_PROGBEGIN);
        endcase
        if (!legal) begin
            plan[0]                = '0;
            plan[0].sequence_error = 1'b1;
            plan_n                 = 1;
        end else begin
            case (func)
                FN_RDSR: begin
                    add_byte(OP_RDSR, 1'b0, 1'b0);
                    add_byte(DUMMY_BYTE, 1'b1, 1'b1);
                end
                FN_WRSR: begin
                    add_byte(OP_WRSR, 1'b0, 1'b0);
                    add_byte(data, 1'b0, 1'b1);
                end
                FN_WREN:  add_byte(OP_WREN, 1'b0, 1'b1);
                FN_WRDIS: add_byte(OP_WRDIS, 1'b0, 1'b1);
                FN_ID: begin
                    add_byte(OP_ID, 1'b0, 1'b0);
                    add_byte(8'h00, 1'b0, 1'b0);
                    add_byte(8'h00, 1'b0, 1'b0);
                    add_byte(8'h00, 1'b0, 1'b0);
                    add_byte(DUMMY_BYTE, 1'b1, 1'b0);
                    add_byte(DUMMY_BYTE, 1'b1, 1'b1);
                end
                FN_CHIPERASE: begin
                    add_byte(OP_WREN, 1'b0, 1'b1);
                    add_byte(OP_CHIPER, 1'b0, 1'b1);
                end
                FN_SECTERASE: begin
                    // sector base wraps at the address width
                    sect_addr = ADDR_BITS'(addr * SECTOR_BYTES);
                    add_byte(OP_WREN, 1'b0, 1'b1);
                    add_byte(OP_SECTER, 1'b0, 1'b0);
                    add_addr(sect_addr);
                    plan[plan_n-1].release_select = 1'b1;
                end
                FN_PDOWN: add_byte(OP_PDOWN, 1'b0, 1'b1);
                FN_WAKE:  add_byte(OP_WAKE, 1'b0, 1'b1);
                FN_RDBEGIN: begin
                    add_byte(OP_READ, 1'b0, 1'b0);
                    add_addr(addr);
                    txn_kind = KIND_READ;
                end
                FN_RDNEXT: begin
                    add_byte(DUMMY_BYTE, 1'b1, last);
                    if (last) txn_kind = KIND_NONE;
                end
                FN_PROGBEGIN: begin
                    add_byte(OP_WREN, 1'b0, 1'b1);
                    add_byte(OP_PROG, 1'b0, 1'b0);
                    add_addr(addr);
                    page_pos = int'(addr) % PAGE_BYTES;
                    txn_kind = KIND_PROG;
                end
                default: begin
                    // program byte, closes itself at the page end
                    page_pos++;
                    full = (page_pos >= PAGE_BYTES);
                    add_byte(data, 1'b0, last | full);
                    plan[plan_n-1].page_full = full;
                    if (last || full) begin
                        txn_kind = KIND_NONE;
                        page_pos = 0;
                    end
                end
            endcase
        end
        plan[plan_n-1].last_of_run = 1'b1;
        for (int i = 0; i < plan_n; i++) expected_bytes.push_back(plan[i]);
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        beat_t want;
        if (!aresetn) begin
            txn_kind = KIND_NONE;
            page_pos = 0;
            expected_bytes.delete();
            mismatches = 0;
            outstanding <= 0;
        end else begin
            // outputs first: a request never answers on its own accept edge
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected bus byte, expected none, actual 0x%0h",
                             $time, m_mosi_byte);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("mosi_byte", int'(want.mosi_byte), int'(m_mosi_byte));
                    check_field("capture_miso", int'(want.capture_miso),
                                int'(m_capture_miso));
                    check_field("release_select", int'(want.release_select),
                                int'(m_release_select));
                    check_field("last_of_run", int'(want.last_of_run),
                                int'(m_last_of_run));
                    check_field("page_full", int'(want.page_full), int'(m_page_full));
                    check_field("sequence_error", int'(want.sequence_error),
                                int'(m_sequence_error));
                end
            end
            if (s_valid && s_ready) begin
                plan_bus_bytes(s_func, s_address, s_data_byte, s_data_last);
            end
            outstanding <= expected_bytes.size();
        end
    end

endmodule

/* sim/spi_nor_flash_command_sequencer_unit_tb.sv */
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_unit_tb
// drives requests into the flash command sequencer, directed then random
// sequences of reads, programs and simple commands, with bursty stalls on
// both channels; the checker beside the block predicts every bus byte
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_unit_tb import sncs_pkg::*;;

    localparam int QUIET_LIMIT  = 4000;  // cycles with no beat on either side
    localparam int LONG_HOLD    = 160;   // receiver hold-off, fills the block
    localparam int DRAIN_CYCLES = 20;    // settle time after the last byte
    localparam int TOTAL_ITEMS  = 130;

    // request codes outside the defined set
    localparam logic [3:0] FN_UNUSED_LO = 4'd13;
    localparam logic [3:0] FN_UNUSED_HI = 4'd15;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;

    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [3:0]  s_func        = '0;
    logic [23:0] s_address     = '0;
    logic [7:0]  s_data_byte   = '0;
    logic        s_data_last   = 1'b0;

    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [7:0]  m_mosi_byte;
    logic        m_capture_miso;
    logic        m_release_select;
    logic        m_last_of_run;
    logic        m_page_full;
    logic        m_sequence_error;

    // flags from the stimulus to the receiver
    bit          idle_on       = 1'b1;
    bit          rx_hold_req   = 1'b0;
    bit          rx_hold_done  = 1'b0;
    int          rx_hold_cnt   = 0;
    int          rx_gap        = 0;

    int          items_sent    = 0;
    int          quiet_cycles  = 0;
    int          mismatches;
    int          outstanding;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    spi_nor_flash_command_sequencer_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_address        (s_address),
        .s_data_byte      (s_data_byte),
        .s_data_last      (s_data_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mosi_byte      (m_mosi_byte),
        .m_capture_miso   (m_capture_miso),
        .m_release_select (m_release_select),
        .m_last_of_run    (m_last_of_run),
        .m_page_full      (m_page_full),
        .m_sequence_error (m_sequence_error)
    );

    sncs_bus_byte_checker chk (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_address        (s_address),
        .s_data_byte      (s_data_byte),
        .s_data_last      (s_data_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mosi_byte      (m_mosi_byte),
        .m_capture_miso   (m_capture_miso),
        .m_release_select (m_release_select),
        .m_last_of_run    (m_last_of_run),
        .m_page_full      (m_page_full),
        .m_sequence_error (m_sequence_error),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    // receiver: one long hold-off on request, else random stall bursts
    // while idling is on, always ready when it is off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_cnt != 0) begin
            m_ready     <= 1'b0;
            rx_hold_cnt <= rx_hold_cnt - 1;
        end else if (rx_hold_req && !rx_hold_done) begin
            m_ready      <= 1'b0;
            rx_hold_cnt  <= LONG_HOLD - 1;
            rx_hold_done <= 1'b1;
        end else if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (rx_gap != 0) begin
            m_ready <= 1'b0;
            rx_gap  <= rx_gap - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            rx_gap  <= $urandom_range(0, 12);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one request beat, maybe after a random gap, and wait for accept
    task automatic send_request(input logic [3:0] f, input logic [23:0] a,
                                input logic [7:0] d, input logic l);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= f;
        s_address   <= a;
        s_data_byte <= d;
        s_data_last <= l;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // stop offering until every predicted byte has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    initial begin
        int          pick;
        int          n;
        bit          paused;
        logic [23:0] a;

        paused = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every command, address extremes, illegal requests,
        // page boundary with and without data_last
        send_request(FN_RDSR, 24'h000000, 8'h00, 1'b0);
        send_request(FN_WRSR, 24'hFFFFFF, 8'hFF, 1'b1);
        send_request(FN_WRSR, 24'h000000, 8'h00, 1'b0);
        send_request(FN_WREN, 24'h000000, 8'h00, 1'b0);
        send_request(FN_WRDIS, 24'h000000, 8'h00, 1'b0);
        send_request(FN_ID, 24'h000000, 8'h00, 1'b0);
        send_request(FN_CHIPERASE, 24'h000000, 8'h00, 1'b0);
        send_request(FN_SECTERASE, 24'h000000, 8'h00, 1'b0);
        send_request(FN_SECTERASE, 24'hFFFFFF, 8'h00, 1'b0);  // sector base wraps
        send_request(FN_PDOWN, 24'h000000, 8'h00, 1'b0);
        send_request(FN_WAKE, 24'h000000, 8'h00, 1'b0);
        send_request(FN_RDBEGIN, 24'hFFFFFF, 8'h00, 1'b0);
        send_request(FN_RDNEXT, 24'h000000, 8'h00, 1'b0);
        send_request(FN_WREN, 24'h000000, 8'h00, 1'b0);       // illegal, read open
        send_request(FN_RDNEXT, 24'h000000, 8'h00, 1'b1);
        send_request(FN_RDNEXT, 24'h000000, 8'h00, 1'b1);     // illegal, none open
        send_request(FN_PROGBYTE, 24'h000000, 8'h5A, 1'b1);   // illegal, none open
        send_request(FN_UNUSED_LO, 24'h000000, 8'h00, 1'b0);
        send_request(FN_UNUSED_HI, 24'hFFFFFF, 8'hFF, 1'b1);
        send_request(FN_PROGBEGIN, 24'h0000FE, 8'h00, 1'b0);
        send_request(FN_PROGBYTE, 24'h000000, 8'hFF, 1'b0);
        send_request(FN_RDSR, 24'h000000, 8'h00, 1'b0);       // illegal, program open
        send_request(FN_PROGBYTE, 24'h000000, 8'h00, 1'b0);   // fills the page
        send_request(FN_PROGBEGIN, 24'hABCDFF, 8'h00, 1'b0);
        send_request(FN_PROGBYTE, 24'h000000, 8'hA5, 1'b1);   // page end and last
        send_request(FN_PROGBEGIN, 24'h000010, 8'h00, 1'b0);
        send_request(FN_PROGBYTE, 24'h000000, 8'h3C, 1'b1);   // ordinary close

        // random: mostly well-formed read and program sequences with random
        // content, plus simple commands, broken sequences and noise
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= 55) rx_hold_req <= 1'b1;
            if (items_sent >= 80 && !paused) begin
                paused = 1'b1;
                wait_drained();
            end
            // a stretch without idling, then none for the tail of the run
            idle_on <= !((items_sent >= 90 && items_sent < 100) || items_sent >= 110);

            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                send_request(4'($urandom_range(0, 8)), 24'($urandom()),
                             8'($urandom()), 1'($urandom_range(0, 1)));
            end else if (pick < 6) begin
                send_request(FN_RDBEGIN, 24'($urandom()), 8'($urandom()),
                             1'($urandom_range(0, 1)));
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        send_request(4'($urandom_range(0, 15)), 24'($urandom()),
                                     8'($urandom()), 1'($urandom_range(0, 1)));
                    end
                    send_request(FN_RDNEXT, 24'($urandom()), 8'($urandom()),
                                 1'(k == n - 1));
                end
            end else if (pick < 9) begin
                // start near the page end half the time to reach the boundary
                a = 24'($urandom());
                if ($urandom_range(0, 1) == 1) a[7:0] = 8'($urandom_range(248, 255));
                send_request(FN_PROGBEGIN, a, 8'($urandom()), 1'($urandom_range(0, 1)));
                n = $urandom_range(1, 10);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        send_request(4'($urandom_range(0, 15)), 24'($urandom()),
                                     8'($urandom()), 1'($urandom_range(0, 1)));
                    end
                    send_request(FN_PROGBYTE, 24'($urandom()), 8'($urandom()),
                                 1'(k == n - 1));
                end
            end else begin
                send_request(4'($urandom_range(0, 15)), 24'($urandom()),
                             8'($urandom()), 1'($urandom_range(0, 1)));
            end
        end

        // drain, let the block settle, then the verdict
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
